/* src/gn2d_pkg.sv */
package gn2d_pkg;

  localparam int TableSize = 256;
  localparam int IdxW      = $clog2(TableSize);
  localparam int FracBits  = 16;
  localparam int OutFrac   = 16;
  localparam int OutW      = 19;
  localparam int OutLimit  = 131072;

  typedef enum logic {
    CMD_EVAL  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_e;

  typedef enum logic {
    ST_FILL = 1'b0,
    ST_RUN  = 1'b1
  } fill_state_e;

  typedef logic [7:0] perm_t;

  // Reference permutation packed with entry 0 in the top byte
  localparam logic [2047:0] BasePerm = {
    8'd151, 8'd160, 8'd137, 8'd91, 8'd90, 8'd15, 8'd131, 8'd13, 8'd201, 8'd95,
    8'd96, 8'd53, 8'd194, 8'd233, 8'd7, 8'd225, 8'd140, 8'd36, 8'd103, 8'd30,
    8'd69, 8'd142, 8'd8, 8'd99, 8'd37, 8'd240, 8'd21, 8'd10, 8'd23, 8'd190,
    8'd6, 8'd148, 8'd247, 8'd120, 8'd234, 8'd75, 8'd0, 8'd26, 8'd197, 8'd62,
    8'd94, 8'd252, 8'd219, 8'd203, 8'd117, 8'd35, 8'd11, 8'd32, 8'd57, 8'd177,
    8'd33, 8'd88, 8'd237, 8'd149, 8'd56, 8'd87, 8'd174, 8'd20, 8'd125, 8'd136,
    8'd171, 8'd168, 8'd68, 8'd175, 8'd74, 8'd165, 8'd71, 8'd134, 8'd139, 8'd48,
    8'd27, 8'd166, 8'd77, 8'd146, 8'd158, 8'd231, 8'd83, 8'd111, 8'd229, 8'd122,
    8'd60, 8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92, 8'd41, 8'd55, 8'd46,
    8'd245, 8'd40, 8'd244, 8'd102, 8'd143, 8'd54, 8'd65, 8'd25, 8'd63, 8'd161,
    8'd1, 8'd216, 8'd80, 8'd73, 8'd209, 8'd76, 8'd132, 8'd187, 8'd208, 8'd89,
    8'd18, 8'd169, 8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
    8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3, 8'd64, 8'd52, 8'd217,
    8'd226, 8'd250, 8'd124, 8'd123, 8'd5, 8'd202, 8'd38, 8'd147, 8'd118, 8'd126,
    8'd255, 8'd82, 8'd85, 8'd212, 8'd207, 8'd206, 8'd59, 8'd227, 8'd47, 8'd16,
    8'd58, 8'd17, 8'd182, 8'd189, 8'd28, 8'd42, 8'd223, 8'd183, 8'd170, 8'd213,
    8'd119, 8'd248, 8'd152, 8'd2, 8'd44, 8'd154, 8'd163, 8'd70, 8'd221, 8'd153,
    8'd101, 8'd155, 8'd167, 8'd43, 8'd172, 8'd9, 8'd129, 8'd22, 8'd39, 8'd253,
    8'd19, 8'd98, 8'd108, 8'd110, 8'd79, 8'd113, 8'd224, 8'd232, 8'd178, 8'd185,
    8'd112, 8'd104, 8'd218, 8'd246, 8'd97, 8'd228, 8'd251, 8'd34, 8'd242, 8'd193,
    8'd238, 8'd210, 8'd144, 8'd12, 8'd191, 8'd179, 8'd162, 8'd241, 8'd81, 8'd51,
    8'd145, 8'd235, 8'd249, 8'd14, 8'd239, 8'd107, 8'd49, 8'd192, 8'd214, 8'd31,
    8'd181, 8'd199, 8'd106, 8'd157, 8'd184, 8'd84, 8'd204, 8'd176, 8'd115, 8'd121,
    8'd50, 8'd45, 8'd127, 8'd4, 8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
    8'd222, 8'd114, 8'd67, 8'd29, 8'd24, 8'd72, 8'd243, 8'd141, 8'd128, 8'd195,
    8'd78, 8'd66, 8'd215, 8'd61, 8'd156, 8'd180
  };

  function automatic perm_t base_perm(input logic [IdxW-1:0] idx);
    logic [7:0] k;
    k = 8'(idx);
    return BasePerm[2047 - 8*k -: 8];
  endfunction

endpackage

/* src/gn2d_fade.sv */
// Quintic fade: t^2, t^3, t^4 and t^5 each take one registered stage;
// the polynomial and clamp follow the last register
module gn2d_fade (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [gn2d_pkg::FracBits-1:0]  t_i,
  output logic [gn2d_pkg::FracBits:0]    u_o
);
  import gn2d_pkg::*;

  localparam int F = FracBits;

  logic [F-1:0] t1_q, t2_q, t3_q;
  logic [F-1:0] p2_q, p3_q, p3b_q, p3c_q, p4_q, p4b_q, p5_q;
  logic [2*F-1:0] m2, m3, m4, m5;
  logic signed [F+6:0] poly;

  assign m2 = t_i * t_i;
  assign m4 = p3_q * t2_q;
  assign m5 = p4_q * t3_q;

  // Stage 1: t^2; stage 2: t^3; stage 3: t^4; stage 4: t^5
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q  <= t_i;
      p2_q  <= m2[2*F-1:F];
      t2_q  <= t1_q;
      p3_q  <= m3[2*F-1:F];
      t3_q  <= t2_q;
      p3b_q <= p3_q;
      p4_q  <= m4[2*F-1:F];
      p3c_q <= p3b_q;
      p4b_q <= p4_q;
      p5_q  <= m5[2*F-1:F];
    end
  end
  assign m3 = p2_q * t1_q;

  // Combine after the last product; clamp to [0, one]
  always_comb begin
    poly = $signed({7'd0, p3c_q}) * $signed((F+7)'(10))
         - $signed({7'd0, p4b_q}) * $signed((F+7)'(15))
         + $signed({7'd0, p5_q}) * $signed((F+7)'(6));
    if (poly < 0) u_o = '0;
    else if (poly > $signed((F+7)'(1) <<< F)) u_o = (F+1)'(1) << F;
    else u_o = poly[F:0];
  end
endmodule

/* src/gradient_noise_2d.sv */
// Channel | Direction | Signals
// in      | input     | in_valid_i, in_ready_o, cmd_i, coord_x_i, coord_y_i, entry_*_i
// out     | output    | out_valid_o, out_ready_i, noise_value_o
//
// One item per cycle while the output does not stall.
// After reset a fill pass loads the reference permutation into the
// three table copies; in_ready_o stays low until it ends.
// A stall on the output freezes the whole pipeline; nothing is lost.
// A table write updates each copy at the stage where that copy is read, so it
// takes effect for every item accepted after it.
module gradient_noise_2d (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              cmd_i,
  input  logic [31:0]                       coord_x_i,
  input  logic [31:0]                       coord_y_i,
  input  logic [7:0]                        entry_index_i,
  input  logic [7:0]                        entry_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [gn2d_pkg::OutW-1:0]  noise_value_o
);
  import gn2d_pkg::*;

  localparam int F  = FracBits;
  localparam int GW = F + 3;   // corner dot products and lerps
  localparam int NS = 7;

  logic en, run;
  logic [NS-1:0] v_q;
  logic wr1_q;
  assign en = ~v_q[NS-1] | out_ready_i;
  assign in_ready_o = en & run;

  logic acc, do_eval, do_wr;
  assign acc     = in_valid_i & in_ready_o;
  assign do_eval = acc & (cmd_e'(cmd_i) == CMD_EVAL);
  assign do_wr   = acc & (cmd_e'(cmd_i) == CMD_WRITE);

  // Fill the table copies after reset
  fill_state_e     state_q, state_d;
  logic [IdxW-1:0] fill_cnt_q, fill_cnt_d;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_FILL;
      fill_cnt_q <= '0;
    end else begin
      state_q    <= state_d;
      fill_cnt_q <= fill_cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    fill_cnt_d = fill_cnt_q;
    run        = 1'b0;
    case (state_q)
      ST_FILL: begin
        fill_cnt_d = fill_cnt_q + IdxW'(1);
        if (fill_cnt_q == IdxW'(TableSize - 1)) state_d = ST_RUN;
      end
      ST_RUN: run = 1'b1;
      default: state_d = ST_FILL;
    endcase
  end

  // Advance valid bits; a write rides one stage to reach copies B and C
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= '0;
      wr1_q <= 1'b0;
    end else if (en) begin
      v_q   <= {v_q[NS-2:0], do_eval};
      wr1_q <= do_wr;
    end
  end

  logic [IdxW-1:0] xg, yg;
  logic [F-1:0]    fx, fy;
  assign xg = coord_x_i[F +: IdxW];
  assign yg = coord_y_i[F +: IdxW];
  assign fx = coord_x_i[F-1:0];
  assign fy = coord_y_i[F-1:0];

  // Stage 1 registers
  logic [IdxW-1:0] yg1_q, widx1_q;
  perm_t           wval1_q;
  logic [F-1:0]    fx1_q, fy1_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      yg1_q   <= yg;
      fx1_q   <= fx;
      fy1_q   <= fy;
      widx1_q <= entry_index_i[IdxW-1:0];
      wval1_q <= entry_value_i;
    end
  end

  // Table write ports: fill pass, or the write at the stage of each copy
  logic            we_a, we_bc;
  logic [IdxW-1:0] wa_a, wa_bc;
  perm_t           wd_a, wd_bc;
  always_comb begin
    if (state_q == ST_FILL) begin
      we_a  = 1'b1;
      wa_a  = fill_cnt_q;
      wd_a  = base_perm(fill_cnt_q);
      we_bc = 1'b1;
      wa_bc = fill_cnt_q;
      wd_bc = base_perm(fill_cnt_q);
    end else begin
      we_a  = do_wr;
      wa_a  = entry_index_i[IdxW-1:0];
      wd_a  = entry_value_i;
      we_bc = en & wr1_q;
      wa_bc = widx1_q;
      wd_bc = wval1_q;
    end
  end

  // Copy A: first hash level, read at the input transfer
  perm_t           tab_a_q [TableSize];
  perm_t           rd_a0_q, rd_a1_q;
  logic [IdxW-1:0] ra_a0, ra_a1;
  assign ra_a0 = xg;
  assign ra_a1 = xg + IdxW'(1);
  always_ff @(posedge clk_i) begin
    if (we_a) tab_a_q[wa_a] <= wd_a;
    if (en) begin
      rd_a0_q <= tab_a_q[ra_a0];
      rd_a1_q <= tab_a_q[ra_a1];
    end
  end

  // Copies B and C: corner hashes, read from stage 1
  logic [IdxW-1:0] a, b;
  logic [IdxW-1:0] ra_b0, ra_b1, ra_c0, ra_c1;
  assign a     = rd_a0_q[IdxW-1:0];
  assign b     = rd_a1_q[IdxW-1:0];
  assign ra_b0 = a + yg1_q;
  assign ra_b1 = a + yg1_q + IdxW'(1);
  assign ra_c0 = b + yg1_q;
  assign ra_c1 = b + yg1_q + IdxW'(1);

  perm_t tab_b_q [TableSize];
  perm_t tab_c_q [TableSize];
  perm_t rd_b0_q, rd_b1_q, rd_c0_q, rd_c1_q;
  always_ff @(posedge clk_i) begin
    if (we_bc) begin
      tab_b_q[wa_bc] <= wd_bc;
      tab_c_q[wa_bc] <= wd_bc;
    end
    if (en) begin
      rd_b0_q <= tab_b_q[ra_b0];
      rd_b1_q <= tab_b_q[ra_b1];
      rd_c0_q <= tab_c_q[ra_c0];
      rd_c1_q <= tab_c_q[ra_c1];
    end
  end

  // Stage 2: hold fractions beside the corner hashes
  logic [F-1:0] fx2_q, fy2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      fx2_q <= fx1_q;
      fy2_q <= fy1_q;
    end
  end

  function automatic logic signed [GW-1:0] grad(input logic [1:0] h,
      input logic signed [GW-1:0] dx, input logic signed [GW-1:0] dy);
    logic signed [GW-1:0] gx, gy;
    gx = h[0] ? -dx : dx;
    gy = h[1] ? -dy : dy;
    return gx + gy;
  endfunction

  logic signed [GW-1:0] dx0, dy0, dx1, dy1;
  assign dx0 = $signed({3'b000, fx2_q});
  assign dy0 = $signed({3'b000, fy2_q});
  assign dx1 = dx0 - $signed(GW'(1) << F);
  assign dy1 = dy0 - $signed(GW'(1) << F);

  logic [F:0] u, v;
  gn2d_fade u_fade_x (.clk_i, .en_i(en), .t_i(fx), .u_o(u));
  gn2d_fade u_fade_y (.clk_i, .en_i(en), .t_i(fy), .u_o(v));

  // Stage 3: corner dots; stage 4: hold them until the fades arrive
  logic signed [GW-1:0] g_q [4];
  logic signed [GW-1:0] gh_q [4];
  always_ff @(posedge clk_i) begin
    if (en) begin
      g_q[0] <= grad(rd_b0_q[1:0], dx0, dy0);
      g_q[1] <= grad(rd_b1_q[1:0], dx0, dy1);
      g_q[2] <= grad(rd_c0_q[1:0], dx1, dy0);
      g_q[3] <= grad(rd_c1_q[1:0], dx1, dy1);
      gh_q   <= g_q;
    end
  end

  // Stage 5: lerps along x; hold v for the lerp along y
  logic [F:0] v_d1_q;
  logic signed [GW-1:0] i0_q, i1_q, rr_q, r_q;
  logic signed [GW+F+1:0] p0, p1, p2;
  assign p0 = $signed({1'b0, u}) * (gh_q[2] - gh_q[0]);
  assign p1 = $signed({1'b0, u}) * (gh_q[3] - gh_q[1]);
  always_ff @(posedge clk_i) begin
    if (en) begin
      i0_q   <= gh_q[0] + GW'(p0 >>> F);
      i1_q   <= gh_q[1] + GW'(p1 >>> F);
      v_d1_q <= v;
    end
  end

  // Stage 6: lerp along y
  assign p2 = $signed({1'b0, v_d1_q}) * (i1_q - i0_q);
  always_ff @(posedge clk_i) begin
    if (en) rr_q <= i0_q + GW'(p2 >>> F);
  end

  // Stage 7: scale and saturate
  logic signed [OutW+8:0] sc;
  always_comb begin
    if (F > OutFrac)
      sc = (OutW+9)'((rr_q + $signed(GW'(1) <<< ((F > OutFrac) ? F-OutFrac-1 : 0)))
           >>> (F - OutFrac));
    else
      sc = (OutW+9)'(rr_q) <<< (OutFrac - F);
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (sc > OutLimit) r_q <= GW'(OutLimit);
      else if (sc < -OutLimit) r_q <= -GW'(OutLimit);
      else r_q <= GW'(sc);
    end
  end

  assign out_valid_o   = v_q[NS-1];
  assign noise_value_o = OutW'(r_q);

  logic unused;
  assign unused = ^{coord_x_i[31:F+IdxW], coord_y_i[31:F+IdxW], rd_b0_q[7:2],
                    rd_b1_q[7:2], rd_c0_q[7:2], rd_c1_q[7:2]};

  // Output stays in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (noise_value_o <= OutLimit && noise_value_o >= -OutLimit))
    else $error("noise out of range");
  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(noise_value_o))
    else $error("stalled result changed");
  // Writes never create results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_wr && en |=> !v_q[0])
    else $error("write produced result");
endmodule
